// File: hdl/bhc_pkg.sv
// Shared types, constants and elaboration-time functions for the highpass coefficient engine.
`default_nettype none
package bhc_pkg;

  localparam int RATE_W = 18;
  localparam int FREQ_W = 18;
  localparam int QUAL_W = 16;
  localparam int COEF_W = 32;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_QZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_CLAMP = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI    = PI_Q60 >> 1;
  localparam logic [62:0] TWO_PI_Q60 = 63'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q60    = 64'h1000000000000000;

  // f / rate long division: 60 quotient bits, RD_BITS per stage
  localparam int RD_STEPS = 60;
  localparam int RD_BITS  = 4;
  localparam int RD_STG   = RD_STEPS / RD_BITS;

  // coefficient divider: 35 quotient bits, plus entry and exit stages
  localparam int QBITS   = 35;
  localparam int DIV_LAT = QBITS + 2;

  typedef struct packed {
    logic [FREQ_W-1:0] cutoff_hz;
    logic [QUAL_W-1:0] quality;
  } req_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic [STAT_W-1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [QUAL_W-1:0] quality;
    logic              qzero;
    logic              clamp;
    logic              flip;
  } side_t;

  typedef struct packed {
    logic [RATE_W-1:0]   r;
    logic [RD_STEPS-1:0] t;
  } rdiv_t;

  typedef struct packed {
    logic [62:0]      r;
    logic [QBITS-1:0] q;
    logic [62:0]      den;
    logic [QBITS-1:0] nlow;
    logic             sat;
    logic             neg;
  } div_stage_t;

  function automatic rdiv_t rd_iter(input rdiv_t a, input logic [RATE_W-1:0] d);
    rdiv_t o;
    logic [RATE_W:0] w;
    o = a;
    for (int b = 0; b < RD_BITS; b++) begin
      w = {o.r, 1'b0};
      if (w >= {1'b0, d}) begin
        w = w - {1'b0, d};
        o.t = {o.t[RD_STEPS-2:0], 1'b1};
      end else begin
        o.t = {o.t[RD_STEPS-2:0], 1'b0};
      end
      o.r = w[RATE_W-1:0];
    end
    return o;
  endfunction

  // constant-only helpers below
  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  function automatic logic [63:0] udiv_c(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 from the odd power series, terms in Q62
  function automatic logic [63:0] atan_q60(input int i);
    logic signed [63:0] sum;
    logic [63:0] term;
    int p;
    sum = '0;
    if (i == 0) return PI_Q60 >> 2;
    for (int k = 0; k < 32; k++) begin
      p = i * (2 * k + 1);
      if (p <= 62) begin
        term = udiv_c(64'd1 << (62 - p), 64'(2 * k + 1));
        if (k % 2 == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
    end
    return 64'(sum + 64'sd2) >> 2;
  endfunction

  // 1/gain by Newton steps on the squared gain
  function automatic logic [63:0] cordic_k(input int steps);
    logic [63:0] g2;
    logic [63:0] y;
    logic [63:0] t;
    g2 = ONE_Q60;
    y  = 64'h0999999999999999;
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
    end
    for (int n = 0; n < 6; n++) begin
      t = mul_shr(g2, mul_shr(y, y, 60), 60);
      y = mul_shr(y, 64'h3000000000000000 - t, 61);
    end
    return y;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bhc_if.sv
// Request and result channel interfaces.
`default_nettype none
interface bhc_req_if;
  logic            valid;
  logic            ready;
  bhc_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bhc_rsp_if;
  logic            valid;
  logic            ready;
  bhc_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/bhc_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
`default_nettype none
module bhc_cordic #(
  parameter int STEPS = 24
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] z_in,
  output logic signed [63:0] x_out,
  output logic signed [63:0] y_out
);
  import bhc_pkg::*;

  localparam logic signed [63:0] K_Q60 = cordic_k(STEPS);

  logic signed [63:0] xs [STEPS];
  logic signed [63:0] ys [STEPS];
  logic signed [63:0] zs [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic signed [63:0] ANG = atan_q60(i);
    logic signed [63:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = K_Q60;
      assign yi = '0;
      assign zi = z_in;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[63]) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - ANG;
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + ANG;
        end
      end
    end
  end

  assign x_out = xs[STEPS-1];
  assign y_out = ys[STEPS-1];

endmodule
`default_nettype wire

// File: hdl/bhc_div.sv
// Pipelined restoring divider: one coefficient ratio, rounded and saturated.
`default_nettype none
module bhc_div #(
  parameter int FRAC = 30
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [63:0]               mag,
  input  logic [62:0]               den,
  input  logic                      neg,
  output logic signed [bhc_pkg::COEF_W-1:0] coef
);
  import bhc_pkg::*;

  localparam int SHL = (FRAC > QBITS - 1) ? FRAC - (QBITS - 1) : 0;
  localparam int SHR = (FRAC < QBITS - 1) ? (QBITS - 1) - FRAC : 0;
  localparam int CW  = 64 + ((SHL > SHR) ? SHL : SHR);
  localparam logic [QBITS-1:0] SAT_M = QBITS'(64'd1 << COEF_W);
  localparam logic [QBITS-1:0] NEG_LIM = QBITS'(64'd1 << (COEF_W - 1));
  localparam logic [QBITS-1:0] POS_LIM = NEG_LIM - 1'b1;

  div_stage_t st [QBITS+1];

  logic [CW-1:0] lhs, rhs, r0;
  assign lhs = CW'(mag) << SHL;
  assign rhs = CW'(den) << SHR;
  assign r0  = lhs >> SHR;

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].r    <= r0[62:0];
      st[0].q    <= '0;
      st[0].den  <= den;
      st[0].nlow <= QBITS'(mag << (FRAC + 1));
      st[0].sat  <= lhs >= rhs;
      st[0].neg  <= neg;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_bit
    logic [63:0] w;
    logic        ge;
    div_stage_t  nxt;
    always_comb begin
      w   = {st[k-1].r, st[k-1].nlow[QBITS-k]};
      ge  = w >= {1'b0, st[k-1].den};
      nxt = st[k-1];
      if (ge) w = w - {1'b0, st[k-1].den};
      nxt.r = w[62:0];
      nxt.q[QBITS-k] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) st[k] <= nxt;
    end
  end

  logic [QBITS:0]   qp1;
  logic [QBITS-1:0] m, mc;
  always_comb begin
    qp1 = {1'b0, st[QBITS].q} + 1'b1;
    m   = st[QBITS].sat ? SAT_M : qp1[QBITS:1];
    if (st[QBITS].neg) mc = (m > NEG_LIM) ? NEG_LIM : m;
    else mc = (m > POS_LIM) ? POS_LIM : m;
  end

  always_ff @(posedge clk) begin
    if (en) coef <= st[QBITS].neg ? -$signed(mc[COEF_W-1:0]) : $signed(mc[COEF_W-1:0]);
  end

endmodule
`default_nettype wire

// File: hdl/biquad_highpass_coefficients.sv
// Top level: highpass biquad coefficient engine, fully pipelined.
//
//  channel   dir  handshake        payload
//  req       in   valid/ready      cutoff_hz, quality
//  rsp       out  valid/ready      coef_b0..coef_a2, status
//  cfg       in   cfg_wen          cfg_wdata -> sample_rate
//
// One request per cycle while the output register is taken; the pipeline depth is set by the
// 60-bit frequency division (4 bits a stage), the CORDIC stages and the 35-bit
// coefficient dividers (one bit a stage).
// Reset clears all stage valids and loads sample_rate with 48000.
// The whole pipeline holds while the output register is full and not taken.
`default_nettype none
module biquad_highpass_coefficients #(
  parameter int COEF_FRAC_BITS = 30,
  parameter int CORDIC_STEPS   = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  bhc_req_if.sink                      req,
  bhc_rsp_if.source                    rsp,
  input  logic                         cfg_wen,
  input  logic [bhc_pkg::RATE_W-1:0]   cfg_wdata
);
  import bhc_pkg::*;

  localparam int M1   = RD_STG;
  localparam int M2   = M1 + 1;
  localparam int M3   = M2 + 1;
  localparam int P1   = M3 + CORDIC_STEPS + 1;
  localparam int P2   = P1 + 1;
  localparam int P3   = P2 + 1;
  localparam int OUTS = P3 + DIV_LAT + 1;
  localparam int LAT  = OUTS + 1;

  logic [RATE_W-1:0] sample_rate;
  logic              adv;
  logic [LAT-1:0]    vld;
  side_t             side [LAT];
  side_t             side_new, side_m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= RATE_RESET;
    end else if (cfg_wen) begin
      sample_rate <= cfg_wdata;
    end
  end

  assign adv       = !vld[LAT-1] || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], req.valid};
    end
  end

  always_comb begin
    side_new.quality = req.payload.quality;
    side_new.qzero   = req.payload.quality == '0;
    side_new.clamp   = (sample_rate == '0) ||
                       ({req.payload.cutoff_hz, 1'b0} > {1'b0, sample_rate});
    side_new.flip    = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_new;
      for (int k = 1; k < LAT; k++) side[k] <= (k == M3) ? side_m3 : side[k-1];
    end
  end

  // f / sample_rate
  rdiv_t rd [RD_STG];
  rdiv_t rd_first;
  assign rd_first = '{r: req.payload.cutoff_hz, t: '0};

  always_ff @(posedge clk) begin
    if (adv) begin
      rd[0] <= rd_iter(rd_first, sample_rate);
      for (int s = 1; s < RD_STG; s++) rd[s] <= rd_iter(rd[s-1], sample_rate);
    end
  end

  // w0 = ratio * 2 pi
  logic [63:0]  m_ll;
  logic [62:0]  m_lh;
  logic [59:0]  m_hl;
  logic [58:0]  m_hh;
  logic [123:0] m_sum;
  logic [63:0]  m_w0;
  logic         m_flip;
  logic signed [63:0] m_z;
  logic [27:0]  t_hi;
  logic [31:0]  t_lo;

  assign t_hi = rd[RD_STG-1].t[59:32];
  assign t_lo = rd[RD_STG-1].t[31:0];

  assign m_sum = {60'd0, m_ll} + {29'd0, m_lh, 32'd0} + {32'd0, m_hl, 32'd0} +
                 {1'b0, m_hh, 64'd0};
  assign m_flip = m_w0 > HALF_PI;

  always_comb begin
    side_m3      = side[M2];
    side_m3.flip = m_flip;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ll <= t_lo * TWO_PI_Q60[31:0];
      m_lh <= t_lo * TWO_PI_Q60[62:32];
      m_hl <= t_hi * TWO_PI_Q60[31:0];
      m_hh <= t_hi * TWO_PI_Q60[62:32];
      m_w0 <= side[M1].clamp ? PI_Q60 : m_sum[123:60];
      m_z  <= m_flip ? $signed(PI_Q60 - m_w0) : $signed(m_w0);
    end
  end

  logic signed [63:0] c_x, c_y;

  bhc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .en    (adv),
    .z_in  (m_z),
    .x_out (c_x),
    .y_out (c_y)
  );

  // ratio operands
  logic signed [63:0] c60, opc_s, s53, two_q, den_s, n2_s;
  always_comb begin
    c60   = side[P1-1].flip ? -c_x : c_x;
    opc_s = $signed(ONE_Q60) + c60;
    s53   = c_y >>> 7;
    two_q = $signed({2'b00, side[P1-1].quality, 46'd0});
    den_s = two_q + s53;
    n2_s  = two_q - s53;
  end

  logic [63:0] p_opc, p_cmag;
  logic [62:0] p_den, p_n2mag;
  logic        p_n2neg, p_a1neg;

  logic [47:0] p2_olo, p2_ohi, p2_clo, p2_chi;
  logic [62:0] p2_den, p2_n2mag;
  logic        p2_n2neg, p2_a1neg;

  logic [79:0] o80, c80;
  logic [63:0] p3_b0, p3_b1, p3_a1, p3_n2;
  logic [62:0] p3_den;
  logic        p3_n2neg, p3_a1neg;

  assign o80 = {p2_ohi, 32'd0} + {32'd0, p2_olo};
  assign c80 = {p2_chi, 32'd0} + {32'd0, p2_clo};

  always_ff @(posedge clk) begin
    if (adv) begin
      p_opc   <= opc_s[63] ? 64'd0 : opc_s;
      p_cmag  <= c60[63] ? -c60 : c60;
      p_den   <= (den_s[63] || den_s == 64'sd0) ? 63'd1 : den_s[62:0];
      p_n2mag <= n2_s[63] ? 63'(-n2_s) : n2_s[62:0];
      p_n2neg <= n2_s[63];
      p_a1neg <= !c60[63] && (c60 != 64'sd0);

      p2_olo   <= p_opc[31:0] * side[P1].quality;
      p2_ohi   <= p_opc[63:32] * side[P1].quality;
      p2_clo   <= p_cmag[31:0] * side[P1].quality;
      p2_chi   <= p_cmag[63:32] * side[P1].quality;
      p2_den   <= p_den;
      p2_n2mag <= p_n2mag;
      p2_n2neg <= p_n2neg;
      p2_a1neg <= p_a1neg;

      p3_b0    <= o80[78:15];
      p3_b1    <= o80[77:14];
      p3_a1    <= c80[76:13];
      p3_n2    <= {1'b0, p2_n2mag};
      p3_den   <= p2_den;
      p3_n2neg <= p2_n2neg;
      p3_a1neg <= p2_a1neg;
    end
  end

  logic signed [COEF_W-1:0] d_b0, d_b1, d_a1, d_a2;

  bhc_div #(.FRAC(COEF_FRAC_BITS)) u_div_b0 (
    .clk (clk), .en (adv), .mag (p3_b0), .den (p3_den), .neg (1'b0), .coef (d_b0)
  );
  bhc_div #(.FRAC(COEF_FRAC_BITS)) u_div_b1 (
    .clk (clk), .en (adv), .mag (p3_b1), .den (p3_den), .neg (1'b1), .coef (d_b1)
  );
  bhc_div #(.FRAC(COEF_FRAC_BITS)) u_div_a1 (
    .clk (clk), .en (adv), .mag (p3_a1), .den (p3_den), .neg (p3_a1neg), .coef (d_a1)
  );
  bhc_div #(.FRAC(COEF_FRAC_BITS)) u_div_a2 (
    .clk (clk), .en (adv), .mag (p3_n2), .den (p3_den), .neg (p3_n2neg), .coef (d_a2)
  );

  rsp_t out_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side[OUTS-1].qzero) begin
        out_q <= '{coef_b0: '0, coef_b1: '0, coef_b2: '0, coef_a1: '0, coef_a2: '0,
                   status: ST_QZERO};
      end else begin
        out_q <= '{coef_b0: d_b0, coef_b1: d_b1, coef_b2: d_b0, coef_a1: d_a1,
                   coef_a2: d_a2, status: side[OUTS-1].clamp ? ST_CLAMP : ST_OK};
      end
    end
  end

  assign rsp.valid   = vld[LAT-1];
  assign rsp.payload = out_q;

endmodule
`default_nettype wire
